// File: src/bvs_pkg.sv
// Shared types and constants for the bounded vector store.
// Used by the controller and the top level; no dependencies.
package bvs_pkg;

   localparam int ACT_W   = 3;
   localparam int POS_W   = 10;
   localparam int DATA_W  = 32;
   localparam int COUNT_W = 11;
   localparam int STAT_W  = 2;

   // Request action codes
   typedef enum logic [ACT_W-1:0] {
      ACT_APPEND    = 3'd0,
      ACT_READ      = 3'd1,
      ACT_WRITE     = 3'd2,
      ACT_REMOVE_AT = 3'd3,
      ACT_REMOVE_EQ = 3'd4
   } action_type;

   // Response status codes
   typedef enum logic [STAT_W-1:0] {
      STATUS_OK     = 2'd0,
      STATUS_BOUNDS = 2'd1,
      STATUS_FULL   = 2'd2
   } status_type;

   // One response as it leaves the controller
   typedef struct packed {
      status_type         status;
      logic [DATA_W-1:0]  read_value;
      logic [COUNT_W-1:0] element_count;
   } result_type;

endpackage

// File: src/bvs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module bvs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/bvs_ctrl.sv
// Request sequencer: decodes actions, drives the element RAM and walks it for removals.
// Depends on bvs_pkg.
module bvs_ctrl import bvs_pkg::*; #(
   parameter int CAPACITY = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [ACT_W-1:0]            req_action,
   input  logic [POS_W-1:0]            req_position,
   input  logic [DATA_W-1:0]           req_value,
   input  logic                        out_free,
   output logic                        res_valid,
   output result_type                  res,
   output logic                        mem_wr_en,
   output logic [$clog2(CAPACITY)-1:0] mem_wr_addr,
   output logic [DATA_W-1:0]           mem_wr_data,
   output logic                        mem_rd_en,
   output logic [$clog2(CAPACITY)-1:0] mem_rd_addr,
   input  logic [DATA_W-1:0]           mem_rd_data
);

   localparam int AW    = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EXEC = 4'b0010,
      S_LOOP = 4'b0100,
      S_HOLD = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   action_type        act_ff, act_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [DATA_W-1:0] val_ff, val_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic              rd_pend_ff, rd_pend_in;
   status_type        hold_status_ff, hold_status_in;
   logic [DATA_W-1:0] hold_data_ff, hold_data_in;

   logic              in_bounds;
   logic              full;
   logic              done;
   status_type        done_status;
   logic [DATA_W-1:0] done_data;

   assign in_bounds = CMP_W'(pos_ff) < CMP_W'(count_ff);
   assign full      = count_ff == CNT_W'(CAPACITY);
   assign req_stall = state_ff != S_IDLE;

   // Sequence one request at a time through the RAM
   always_comb begin
      state_in       = state_ff;
      act_in         = act_ff;
      pos_in         = pos_ff;
      val_in         = val_ff;
      count_in       = count_ff;
      rd_ptr_in      = rd_ptr_ff;
      wr_ptr_in      = wr_ptr_ff;
      rd_pend_in     = rd_pend_ff;
      hold_status_in = hold_status_ff;
      hold_data_in   = hold_data_ff;
      mem_rd_en      = 1'b0;
      mem_rd_addr    = AW'(rd_ptr_ff);
      mem_wr_en      = 1'b0;
      mem_wr_addr    = AW'(wr_ptr_ff);
      mem_wr_data    = mem_rd_data;
      done           = 1'b0;
      done_status    = STATUS_OK;
      done_data      = '0;
      res_valid      = 1'b0;
      res.status        = hold_status_ff;
      res.read_value    = hold_data_ff;
      res.element_count = COUNT_W'(count_ff);

      unique case (state_ff)
         S_IDLE: begin
            // Read ahead at the requested position so a read finishes next cycle
            mem_rd_en   = 1'b1;
            mem_rd_addr = AW'(req_position);
            if (req_valid) begin
               act_in   = action_type'(req_action);
               pos_in   = req_position;
               val_in   = req_value;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (act_ff)
               ACT_APPEND: begin
                  done = 1'b1;
                  if (full) begin
                     done_status = STATUS_FULL;
                  end else begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = AW'(count_ff);
                     mem_wr_data = val_ff;
                     count_in    = count_ff + CNT_W'(1);
                  end
               end
               ACT_READ: begin
                  done = 1'b1;
                  if (in_bounds) begin
                     done_data = mem_rd_data;
                  end else begin
                     done_status = STATUS_BOUNDS;
                  end
               end
               ACT_WRITE: begin
                  done = 1'b1;
                  if (in_bounds) begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = AW'(pos_ff);
                     mem_wr_data = val_ff;
                  end else begin
                     done_status = STATUS_BOUNDS;
                  end
               end
               ACT_REMOVE_AT: begin
                  if (in_bounds) begin
                     rd_ptr_in  = CNT_W'(pos_ff) + CNT_W'(1);
                     wr_ptr_in  = CNT_W'(pos_ff);
                     rd_pend_in = 1'b0;
                     state_in   = S_LOOP;
                  end else begin
                     done        = 1'b1;
                     done_status = STATUS_BOUNDS;
                  end
               end
               ACT_REMOVE_EQ: begin
                  rd_ptr_in  = '0;
                  wr_ptr_in  = '0;
                  rd_pend_in = 1'b0;
                  state_in   = S_LOOP;
               end
               default: begin
                  done = 1'b1;
               end
            endcase
         end
         S_LOOP: begin
            // Write back the element read last cycle if it is kept
            if (rd_pend_ff && (act_ff == ACT_REMOVE_AT || mem_rd_data != val_ff)) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = AW'(wr_ptr_ff);
               mem_wr_data = mem_rd_data;
               wr_ptr_in   = wr_ptr_ff + CNT_W'(1);
            end
            // Advance the read pointer; finish once the pipe is drained
            if (rd_ptr_ff < count_ff) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = AW'(rd_ptr_ff);
               rd_ptr_in   = rd_ptr_ff + CNT_W'(1);
               rd_pend_in  = 1'b1;
            end else begin
               rd_pend_in = 1'b0;
               if (!rd_pend_ff) begin
                  done     = 1'b1;
                  count_in = wr_ptr_ff;
               end
            end
         end
         S_HOLD: begin
            if (out_free) begin
               res_valid = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Hand the result to the output register, or hold it while that is busy
      if (done) begin
         if (out_free) begin
            res_valid         = 1'b1;
            res.status        = done_status;
            res.read_value    = done_data;
            res.element_count = COUNT_W'(count_in);
            state_in          = S_IDLE;
         end else begin
            hold_status_in = done_status;
            hold_data_in   = done_data;
            state_in       = S_HOLD;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         rd_pend_ff <= rd_pend_in;
      end
   end

   // Request and walk registers
   always_ff @(posedge clock) begin
      act_ff         <= act_in;
      pos_ff         <= pos_in;
      val_ff         <= val_in;
      rd_ptr_ff      <= rd_ptr_in;
      wr_ptr_ff      <= wr_ptr_in;
      hold_status_ff <= hold_status_in;
      hold_data_ff   <= hold_data_in;
   end

endmodule

// File: src/bounded_vector_store_core.sv
// Bounded vector store: up to CAPACITY signed 32-bit elements held in one
// synchronous RAM, with a live count. Each request transfer gives exactly one
// response transfer. Append, read, write, out-of-range requests and unused
// action codes are done in the execute state. Remove at position and remove
// all equal walk the elements above the position, or all elements, through
// the RAM's single read and single write port, one element per cycle. One
// request is in progress at a time; a finished response waits in the output
// register while the next request is taken. The RAM contents are not cleared
// at reset; only entries below the live count are ever returned or moved.
// Depends on bvs_pkg, bvs_ctrl and bvs_ram.
module bounded_vector_store_core import bvs_pkg::*; #(
   parameter int CAPACITY = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [ACT_W-1:0]          req_action,
   input  logic [POS_W-1:0]          req_position,
   input  logic signed [DATA_W-1:0]  req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [STAT_W-1:0]         rsp_status,
   output logic signed [DATA_W-1:0]  rsp_read_value,
   output logic [COUNT_W-1:0]        rsp_element_count
);

   localparam int AW = $clog2(CAPACITY);

   logic              out_free;
   logic              res_valid;
   result_type        res;
   logic              mem_wr_en;
   logic [AW-1:0]     mem_wr_addr;
   logic [DATA_W-1:0] mem_wr_data;
   logic              mem_rd_en;
   logic [AW-1:0]     mem_rd_addr;
   logic [DATA_W-1:0] mem_rd_data;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_ff;

   bvs_ctrl #(
      .CAPACITY(CAPACITY)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_action   (req_action),
      .req_position (req_position),
      .req_value    (req_value),
      .out_free     (out_free),
      .res_valid    (res_valid),
      .res          (res),
      .mem_wr_en    (mem_wr_en),
      .mem_wr_addr  (mem_wr_addr),
      .mem_wr_data  (mem_wr_data),
      .mem_rd_en    (mem_rd_en),
      .mem_rd_addr  (mem_rd_addr),
      .mem_rd_data  (mem_rd_data)
   );

   bvs_ram #(
      .WIDTH(DATA_W),
      .DEPTH(CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Output register: load a new response when the slot is empty or draining
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_ff.status;
   assign rsp_read_value    = rsp_ff.read_value;
   assign rsp_element_count = rsp_ff.element_count;

   // Never overwrite a response that has not been transferred
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> out_free)
      else $error("response loaded while output register busy");

   // One request in progress: a request transfer stalls the next cycle
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while another is in progress");

   // Read data is zero unless the request succeeded
   a_read_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_OK) |-> (rsp_read_value == '0))
      else $error("nonzero read value on failed request");

   // Full status only with the store at capacity
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_FULL) |->
         (rsp_element_count == COUNT_W'(CAPACITY)))
      else $error("full status with store below capacity");

endmodule
